@@ design/nfa_pkg.sv @@
// Shared constants, codes and controller/datapath types for the address pool allocator.
`timescale 1ns / 1ps
`default_nettype none
package nfa_pkg;

  // Pool geometry
  localparam int POOL_CAPACITY = 256;
  localparam int SLOT_W        = (POOL_CAPACITY > 1) ? $clog2(POOL_CAPACITY) : 1;
  localparam int LEN_W         = $clog2(POOL_CAPACITY + 1);
  localparam int LEN_REG_W     = 9;
  localparam int CNT_W         = (LEN_W > LEN_REG_W) ? LEN_W : LEN_REG_W;
  localparam int ADDR_W        = 16;
  localparam int CFG_IDX_W     = 2;
  localparam int CFG_DATA_W    = 16;

  // Operation codes of a request transaction
  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_PRESENT = 2'd2,
    OP_ABSENT  = 2'd3
  } op_e;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POOL_START  = 2'd0,
    REG_POOL_LENGTH = 2'd1,
    REG_OWN_ADDRESS = 2'd2
  } cfg_reg_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_CHECK,
    ST_MODIFY,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;   // latch request and scan start position
    logic rd_slot;   // read entry of the addressed slot
    logic rd_pos;    // read entry at current scan position
    logic rd_next;   // step scan position and read there
    logic grant;     // claim current scan slot
    logic modify;    // write back release/mark update
    logic fail;      // result: address 0, success 0
    logic load_out;  // move result into output register
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_alloc;
    logic pool_empty;
    logic slot_hit;
    logic slot_free;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage
`default_nettype wire

@@ design/nfa_req_if.sv @@
// Request channel: operation and bus address with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface nfa_req_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 operation;
  logic [nfa_pkg::ADDR_W-1:0] bus_address;

  modport source (output valid, output operation, output bus_address, input ready);
  modport sink   (input valid, input operation, input bus_address, output ready);
endinterface
`default_nettype wire

@@ design/nfa_rsp_if.sv @@
// Response channel: granted address and success flag with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none
interface nfa_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [nfa_pkg::ADDR_W-1:0] granted_address;
  logic                       success;

  modport source (output valid, output granted_address, output success, input ready);
  modport sink   (input valid, input granted_address, input success, output ready);
endinterface
`default_nettype wire

@@ design/next_fit_address_pool_allocator_top.sv @@
// Top level of the next-fit bus address pool allocator: controller plus datapath.
// Allocate scans the pool next-fit from the slot after the last grant, one slot per cycle
// through the slot memory read port, over at most the pool length; release and marks
// update the slot only for an address in the pool. Allocate on an empty pool fails without a scan.
// One transaction in flight; the next can be accepted in the cycle after its result is loaded into
// the output register. Reset clears config, valid bits and state; pool writes clear all slots.
`timescale 1ns / 1ps
`default_nettype none
module next_fit_address_pool_allocator_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  nfa_req_if.sink                             req,
  nfa_rsp_if.source                           rsp
);

  nfa_pkg::cmd_t cmd;
  nfa_pkg::sts_t sts;

  nfa_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req.valid),
    .in_ready_o (req.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  nfa_datapath u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .in_operation_i        (req.operation),
    .in_bus_address_i      (req.bus_address),
    .cmd_i                 (cmd),
    .sts_o                 (sts),
    .out_valid_o           (rsp.valid),
    .out_ready_i           (rsp.ready),
    .out_granted_address_o (rsp.granted_address),
    .out_success_o         (rsp.success)
  );

endmodule
`default_nettype wire

@@ design/nfa_controller.sv @@
// Controller state machine sequencing lookup, pool scan, update and response.
`timescale 1ns / 1ps
`default_nettype none
module nfa_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  input  wire nfa_pkg::sts_t sts_i,
  output nfa_pkg::cmd_t      cmd_o
);

  nfa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= nfa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      nfa_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = nfa_pkg::ST_LOOKUP;
      end
      nfa_pkg::ST_LOOKUP: begin
        if (sts_i.is_alloc) begin
          state_d = sts_i.pool_empty ? nfa_pkg::ST_FINISH : nfa_pkg::ST_CHECK;
        end else begin
          state_d = sts_i.slot_hit ? nfa_pkg::ST_MODIFY : nfa_pkg::ST_FINISH;
        end
      end
      nfa_pkg::ST_CHECK: begin
        if (sts_i.slot_free || sts_i.scan_done) state_d = nfa_pkg::ST_FINISH;
      end
      nfa_pkg::ST_MODIFY: begin
        state_d = nfa_pkg::ST_FINISH;
      end
      nfa_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = nfa_pkg::ST_IDLE;
      end
      default: state_d = nfa_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      nfa_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      nfa_pkg::ST_LOOKUP: begin
        if (sts_i.is_alloc) begin
          cmd_o.rd_pos = !sts_i.pool_empty;
          cmd_o.fail   = sts_i.pool_empty;
        end else begin
          cmd_o.rd_slot = sts_i.slot_hit;
          cmd_o.fail    = !sts_i.slot_hit;
        end
      end
      nfa_pkg::ST_CHECK: begin
        if (sts_i.slot_free) begin
          cmd_o.grant = 1'b1;
        end else if (sts_i.scan_done) begin
          cmd_o.fail = 1'b1;
        end else begin
          cmd_o.rd_next = 1'b1;
        end
      end
      nfa_pkg::ST_MODIFY: begin
        cmd_o.modify = 1'b1;
      end
      nfa_pkg::ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: cmd_o = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ design/nfa_datapath.sv @@
// Datapath: configuration, slot memory with valid bits, scan position and result registers.
`timescale 1ns / 1ps
`default_nettype none
module nfa_datapath (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic [1:0]                     in_operation_i,
  input  wire logic [nfa_pkg::ADDR_W-1:0]     in_bus_address_i,
  input  wire nfa_pkg::cmd_t                  cmd_i,
  output nfa_pkg::sts_t                       sts_o,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic [nfa_pkg::ADDR_W-1:0]          out_granted_address_o,
  output logic                                out_success_o
);

  localparam int CAP    = nfa_pkg::POOL_CAPACITY;
  localparam int SW     = nfa_pkg::SLOT_W;
  localparam int CW     = nfa_pkg::CNT_W;
  localparam int AW     = nfa_pkg::ADDR_W;
  localparam int LRW    = nfa_pkg::LEN_REG_W;

  // Configuration registers
  logic [AW-1:0]  start_q, own_q;
  logic [LRW-1:0] len_q;
  logic           restart;
  logic [LRW-1:0] len_new;

  // Slot store: bit 0 in use, bit 1 present elsewhere
  logic [1:0]     mem [CAP];
  logic [CAP-1:0] vld_q;
  logic [1:0]     rd_q;
  logic           rd_vld_q;
  logic [1:0]     entry;
  logic           mem_re, mem_we;
  logic [SW-1:0]  mem_ra, mem_wa;
  logic [1:0]     mem_wd;

  // Item and scan state
  logic [1:0]    op_q;
  logic [AW-1:0] addr_q;
  logic [SW-1:0] last_q, last_d, pos_q, pos_next, pos_start;
  logic [CW-1:0] cnt_q, n_eff, n_new;
  logic [AW-1:0] diff, scan_addr;
  logic [SW-1:0] slot;

  // Result and output registers
  logic [AW-1:0] res_addr_q, out_addr_q;
  logic          res_ok_q, out_ok_q, out_valid_q;

  function automatic logic [CW-1:0] eff_len(input logic [LRW-1:0] len);
    logic [CW-1:0] l;
    l = CW'(len);
    return (l > CW'(CAP)) ? CW'(CAP) : l;
  endfunction

  assign n_eff = eff_len(len_q);

  // Configuration writes; pool start or length restarts the pool
  assign restart = cfg_we_i && (cfg_idx_i == nfa_pkg::REG_POOL_START ||
                                cfg_idx_i == nfa_pkg::REG_POOL_LENGTH);
  assign len_new = (cfg_idx_i == nfa_pkg::REG_POOL_LENGTH) ? cfg_data_i[LRW-1:0] : len_q;
  assign n_new   = eff_len(len_new);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= '0;
      len_q   <= '0;
      own_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        nfa_pkg::REG_POOL_START:  start_q <= cfg_data_i[AW-1:0];
        nfa_pkg::REG_POOL_LENGTH: len_q   <= cfg_data_i[LRW-1:0];
        nfa_pkg::REG_OWN_ADDRESS: own_q   <= cfg_data_i[AW-1:0];
        default: ;
      endcase
    end
  end

  // Address to slot translation for release and marks
  assign diff = addr_q - start_q;
  assign slot = diff[SW-1:0];

  // Scan position stepping, wrapping at the pool length
  assign pos_next  = ((CW'(pos_q) + CW'(1)) == n_eff) ? '0 : pos_q + SW'(1);
  assign pos_start = ((CW'(last_q) + CW'(1)) == n_eff) ? '0 : last_q + SW'(1);
  assign scan_addr = start_q + AW'(pos_q);
  assign entry     = rd_vld_q ? rd_q : 2'b00;

  // Memory port selection
  always_comb begin
    mem_re = cmd_i.rd_slot || cmd_i.rd_pos || cmd_i.rd_next;
    mem_ra = pos_q;
    if (cmd_i.rd_slot)      mem_ra = slot;
    else if (cmd_i.rd_next) mem_ra = pos_next;
    mem_we = cmd_i.grant || cmd_i.modify;
    mem_wa = cmd_i.grant ? pos_q : slot;
    mem_wd = 2'b00;
    if (cmd_i.grant) begin
      mem_wd = {entry[1], 1'b1};
    end else begin
      case (nfa_pkg::op_e'(op_q))
        nfa_pkg::OP_RELEASE: mem_wd = {entry[1], 1'b0};
        nfa_pkg::OP_PRESENT: mem_wd = {1'b1, entry[0]};
        nfa_pkg::OP_ABSENT:  mem_wd = {1'b0, entry[0]};
        default:             mem_wd = entry;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) rd_q <= mem[mem_ra];
  end

  // Per-entry valid bits, cleared at reset and on pool restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (restart) begin
        vld_q <= '0;
      end else if (mem_we) begin
        vld_q[mem_wa] <= 1'b1;
      end
      if (mem_re) rd_vld_q <= vld_q[mem_ra];
    end
  end

  // Last granted position
  always_comb begin
    last_d = last_q;
    if (restart) begin
      last_d = (n_new == '0) ? '0 : SW'(n_new - CW'(1));
    end else if (cmd_i.grant) begin
      last_d = pos_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else begin
      last_q <= last_d;
    end
  end

  // Request capture and scan counters
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q   <= in_operation_i;
      addr_q <= in_bus_address_i;
      pos_q  <= pos_start;
      cnt_q  <= CW'(1);
    end else if (cmd_i.rd_next) begin
      pos_q <= pos_next;
      cnt_q <= cnt_q + CW'(1);
    end
  end

  // Result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.grant) begin
      res_addr_q <= scan_addr;
      res_ok_q   <= 1'b1;
    end else if (cmd_i.modify) begin
      res_addr_q <= '0;
      res_ok_q   <= 1'b1;
    end else if (cmd_i.fail) begin
      res_addr_q <= '0;
      res_ok_q   <= 1'b0;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_addr_q <= res_addr_q;
      out_ok_q   <= res_ok_q;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign out_granted_address_o = out_addr_q;
  assign out_success_o         = out_ok_q;

  // Status to controller
  always_comb begin
    sts_o.is_alloc   = (nfa_pkg::op_e'(op_q) == nfa_pkg::OP_ALLOC);
    sts_o.pool_empty = (n_eff == '0);
    sts_o.slot_hit   = (addr_q >= start_q) && (diff < AW'(n_eff));
    sts_o.slot_free  = !entry[0] && !entry[1] && (scan_addr != own_q);
    sts_o.scan_done  = (cnt_q == n_eff);
    sts_o.out_free   = !out_valid_q || out_ready_i;
  end

endmodule
`default_nettype wire

@@ bench/next_fit_address_pool_allocator_top_tb.sv @@
// Self-checking testbench for the next-fit bus address pool allocator.
`timescale 1ns / 1ps
module next_fit_address_pool_allocator_top_tb;

  localparam int AW             = nfa_pkg::ADDR_W;
  localparam int CAP            = nfa_pkg::POOL_CAPACITY;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES    = 300;
  localparam int N_PHASES       = 10;
  localparam int PHASE_ITEMS    = 110;

  typedef struct packed {
    logic [AW-1:0] granted_address;
    logic          success;
  } alloc_rsp_t;

  // Shadow of the allocator: pool registers, slot bitmaps and next-fit cursor
  class pool_scoreboard;
    logic [AW-1:0] pool_start;
    logic [8:0]    pool_len;
    logic [AW-1:0] own_addr;
    bit            in_use [CAP];
    bit            present [CAP];
    int            last_pos;
    alloc_rsp_t    expected_rsps [$];
    int            errors;
    int            checked;
    int            grants;
    int            alloc_fails;
    int            ignored;

    function new();
      pool_start  = '0;
      pool_len    = '0;
      own_addr    = '0;
      errors      = 0;
      checked     = 0;
      grants      = 0;
      alloc_fails = 0;
      ignored     = 0;
      restart();
    endfunction

    function int eff_len();
      return (pool_len > CAP) ? CAP : int'(pool_len);
    endfunction

    function int pending();
      return expected_rsps.size();
    endfunction

    // Pool start or length change wipes both bitmaps
    function void restart();
      int n;
      n = eff_len();
      for (int i = 0; i < CAP; i++) begin
        in_use[i]  = 1'b0;
        present[i] = 1'b0;
      end
      last_pos = (n > 0) ? n - 1 : 0;
    endfunction

    function void configure(nfa_pkg::cfg_reg_e idx, logic [nfa_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nfa_pkg::REG_POOL_START: begin
          pool_start = data;
          restart();
        end
        nfa_pkg::REG_POOL_LENGTH: begin
          pool_len = data[8:0];
          restart();
        end
        nfa_pkg::REG_OWN_ADDRESS: own_addr = data;
        default: ;
      endcase
    endfunction

    // Predict the response of one accepted request transaction
    function void note_request(nfa_pkg::op_e op, logic [AW-1:0] addr);
      alloc_rsp_t    r;
      int            n;
      int            pos;
      int            slot;
      logic [AW-1:0] a;
      n = eff_len();
      r = '0;
      if (op == nfa_pkg::OP_ALLOC) begin
        for (int i = 1; i <= n; i++) begin
          pos = (last_pos + i) % n;
          a   = pool_start + AW'(pos);
          if (!in_use[pos] && !present[pos] && a != own_addr) begin
            last_pos          = pos;
            in_use[pos]       = 1'b1;
            r.granted_address = a;
            r.success         = 1'b1;
            break;
          end
        end
        if (r.success) grants++;
        else alloc_fails++;
      end else begin
        slot = int'(addr) - int'(pool_start);
        if (addr >= pool_start && slot < n) begin
          r.success = 1'b1;
          case (op)
            nfa_pkg::OP_RELEASE: in_use[slot]  = 1'b0;
            nfa_pkg::OP_PRESENT: present[slot] = 1'b1;
            default:             present[slot] = 1'b0;
          endcase
        end else begin
          ignored++;
        end
      end
      expected_rsps = {expected_rsps, r};
    endfunction

    function void check_response(logic [AW-1:0] granted, logic success);
      alloc_rsp_t e;
      if (expected_rsps.size() == 0) begin
        $error("unexpected response: granted_address %h success %b", granted, success);
        errors++;
        return;
      end
      e = expected_rsps.pop_front();
      checked++;
      if (granted !== e.granted_address) begin
        $error("granted_address: expected %h, actual %h", e.granted_address, granted);
        errors++;
      end
      if (success !== e.success) begin
        $error("success: expected %b, actual %b", e.success, success);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni;
  logic                           cfg_we_i;
  logic [nfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [nfa_pkg::CFG_DATA_W-1:0] cfg_data_i;
  bit                             sender_idles;
  bit                             receiver_idles;
  int                             quiet_cycles;
  int                             settings_run;

  pool_scoreboard sb = new();

  nfa_req_if req_if ();
  nfa_rsp_if rsp_if ();

  next_fit_address_pool_allocator_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req        (req_if),
    .rsp        (rsp_if)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Response back-pressure in random bursts
  always begin
    @(negedge clk_i);
    if (receiver_idles && $urandom_range(0, 3) == 0) begin
      rsp_if.ready <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    rsp_if.ready <= 1'b1;
  end

  // Transaction monitor: check responses, predict accepted requests
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready)
        sb.check_response(rsp_if.granted_address, rsp_if.success);
      if (req_if.valid && req_if.ready)
        sb.note_request(nfa_pkg::op_e'(req_if.operation), req_if.bus_address);
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Starts and ends at a falling edge; valid stays high on return
  task automatic send_req(nfa_pkg::op_e op, logic [AW-1:0] addr);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk_i);
    end
    req_if.valid       <= 1'b1;
    req_if.operation   <= op;
    req_if.bus_address <= addr;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
  endtask

  task automatic write_reg(nfa_pkg::cfg_reg_e idx, logic [nfa_pkg::CFG_DATA_W-1:0] data);
    sb.configure(idx, data);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_pool(logic [15:0] start, logic [15:0] len_word, logic [15:0] own);
    write_reg(nfa_pkg::REG_POOL_START, start);
    write_reg(nfa_pkg::REG_POOL_LENGTH, len_word);
    write_reg(nfa_pkg::REG_OWN_ADDRESS, own);
    settings_run++;
  endtask

  // Stop sending and let every outstanding response come back
  task automatic drain();
    req_if.valid <= 1'b0;
    while (sb.pending() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // Mostly addresses inside the pool, plus edges and noise
  function automatic void pick_item(output nfa_pkg::op_e op, output logic [AW-1:0] addr);
    int n;
    int r;
    n = sb.eff_len();
    r = $urandom_range(0, 99);
    if (r < 45)      op = nfa_pkg::OP_ALLOC;
    else if (r < 70) op = nfa_pkg::OP_RELEASE;
    else if (r < 85) op = nfa_pkg::OP_PRESENT;
    else             op = nfa_pkg::OP_ABSENT;
    r = $urandom_range(0, 9);
    if (n > 0 && r < 7) addr = sb.pool_start + AW'($urandom_range(0, n - 1));
    else if (r == 7)    addr = sb.pool_start - AW'(1);
    else if (r == 8)    addr = sb.pool_start + AW'(n);
    else                addr = AW'($urandom);
  endfunction

  initial begin
    nfa_pkg::op_e  op;
    logic [AW-1:0] addr;
    logic [15:0]   start;
    logic [15:0]   len_word;
    logic [15:0]   own;
    int            n;

    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_idx_i          = nfa_pkg::REG_POOL_START;
    cfg_data_i         = '0;
    req_if.valid       = 1'b0;
    req_if.operation   = nfa_pkg::OP_ALLOC;
    req_if.bus_address = '0;
    rsp_if.ready       = 1'b0;
    sender_idles       = 1'b1;
    receiver_idles     = 1'b1;
    settings_run       = 1;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty pool after reset: nothing to grant, nothing to hit
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h0000);
    send_req(nfa_pkg::OP_PRESENT, 16'hFFFF);
    drain();

    // Small pool at zero: address zero granted, own address skipped, pool full
    set_pool(16'h0000, 16'd4, 16'h0002);
    send_req(nfa_pkg::OP_ALLOC, 16'hFFFF);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h0001);
    send_req(nfa_pkg::OP_PRESENT, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_ABSENT, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h0004);
    send_req(nfa_pkg::OP_ABSENT, 16'hFFFF);
    drain();

    // Pool wrapping past the top of the address space
    set_pool(16'hFFFE, 16'd4, 16'h1234);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h0000);
    send_req(nfa_pkg::OP_PRESENT, 16'hFFFF);
    drain();

    // Length above capacity saturates
    set_pool(16'h1000, 16'd300, 16'h10FF);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    send_req(nfa_pkg::OP_RELEASE, 16'h1100);
    send_req(nfa_pkg::OP_RELEASE, 16'h10FF);
    send_req(nfa_pkg::OP_ALLOC, 16'h0000);
    drain();

    // Random phases, one pool setting each, own address moved halfway
    for (int ph = 0; ph < N_PHASES; ph++) begin
      case (ph)
        0: begin start = 16'($urandom); len_word = 16'($urandom_range(1, 16)); end
        1: begin
          start    = 16'hFFFF - 16'($urandom_range(0, 8));
          len_word = 16'($urandom_range(4, 16));
        end
        2: begin start = 16'h0000; len_word = 16'd256; end
        3: begin start = 16'($urandom); len_word = 16'd1; end
        4: begin start = 16'hFFFF; len_word = 16'd511; end
        5: begin start = 16'($urandom); len_word = 16'd0; end
        6: begin
          start    = 16'($urandom);
          len_word = 16'(($urandom_range(1, 127) << 9) | $urandom_range(1, 16));
        end
        7: begin start = 16'($urandom_range(0, 15)); len_word = 16'($urandom_range(2, 8)); end
        default: begin start = 16'($urandom); len_word = 16'($urandom_range(1, 16)); end
      endcase
      n   = (len_word[8:0] > CAP) ? CAP : int'(len_word[8:0]);
      own = (n > 0 && $urandom_range(0, 1)) ? start + 16'($urandom_range(0, n - 1))
                                             : 16'($urandom);
      sender_idles   = !(ph == 3 || ph == N_PHASES - 1);
      receiver_idles = sender_idles;
      set_pool(start, len_word, own);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2) begin
          drain();
          write_reg(nfa_pkg::REG_OWN_ADDRESS, (n > 0 && $urandom_range(0, 1))
                    ? start + 16'($urandom_range(0, n - 1)) : 16'($urandom));
        end
        pick_item(op, addr);
        send_req(op, addr);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk_i);
    $display("Checked %0d responses over %0d pool settings", sb.checked, settings_run);
    $display("%0d grants, %0d failed allocations, %0d addresses outside the pool",
             sb.grants, sb.alloc_fails, sb.ignored);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
